// ===== rtl/core/rtdc_pkg.sv =====
`timescale 1ns / 1ps

package rtdc_pkg;

	// item fields
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CODE_W = 15;
	localparam int unsigned TEMP_W = 19;
	localparam int unsigned IN_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 24;

	// root argument w = base - slope * code, always positive, below 2^47
	localparam int unsigned W_W = 47;
	localparam int unsigned SLOPE_W = 31;
	localparam int unsigned SLOPE_PROD_W = SLOPE_W + CODE_W;
	localparam logic [W_W-1:0] W_BASE = W_W'(64'd1758480889 << 16);
	localparam logic [SLOPE_W-1:0] W_SLOPE = SLOPE_W'(32'd1986600000);

	// square root of w * 2^16, one result bit per stage
	localparam int unsigned SQ_STEPS = 32;
	localparam int unsigned RAD_W = 2 * SQ_STEPS;
	localparam int unsigned ROOT_W = SQ_STEPS;
	localparam int unsigned REM_W = SQ_STEPS + 2;
	localparam int unsigned RAD_PAD_W = RAD_W - W_W - 1;

	// numerator a * 2^16 - root
	localparam int unsigned NUM_W = ROOT_W + 1;
	localparam logic [ROOT_W-1:0] A_SCALED = ROOT_W'(64'd39083 << 16);

	// unit scale factors
	localparam int unsigned MUL_W = 12;
	localparam logic [MUL_W-1:0] C_MUL = MUL_W'(2000);
	localparam logic [MUL_W-1:0] F_MUL = MUL_W'(3600);
	localparam int unsigned PROD_W = NUM_W + MUL_W + 1;

	// rounded divide by 231 * 2^16: add half, shift, then divide by 231
	localparam int unsigned DEN_SHIFT = 16;
	localparam int unsigned X_W = 26;
	localparam logic [PROD_W-1:0] DEN_HALF = PROD_W'(7569408);
	localparam int unsigned RECIP_W = 27;
	localparam int unsigned RECIP_SHIFT = 34;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(74371728);
	localparam int unsigned RPROD_W = X_W + RECIP_W;
	localparam int unsigned QUOT_W = RPROD_W - RECIP_SHIFT;
	localparam int unsigned REMD_W = X_W + 1;
	localparam logic [REMD_W-1:0] DIV = REMD_W'(231);

	localparam logic [TEMP_W-1:0] F_OFFSET = TEMP_W'(3200);
	localparam int signed TEMP_MIN = -42000;
	localparam int signed TEMP_MAX = 182000;

endpackage

// ===== rtl/core/rtdc_isqrt.sv =====
`timescale 1ns / 1ps

module rtdc_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rtdc_pkg::W_W-1:0]     in_w,
	input  logic                         in_fahr,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rtdc_pkg::ROOT_W-1:0]  out_root,
	output logic                         out_fahr
);

	logic [rtdc_pkg::RAD_W-1:0]  rad_s  [rtdc_pkg::SQ_STEPS];
	logic [rtdc_pkg::REM_W-1:0]  rem_s  [rtdc_pkg::SQ_STEPS];
	logic [rtdc_pkg::ROOT_W-1:0] root_s [rtdc_pkg::SQ_STEPS];
	logic                        fahr_s [rtdc_pkg::SQ_STEPS];
	logic                        vld_s  [rtdc_pkg::SQ_STEPS];
	logic                        adv    [rtdc_pkg::SQ_STEPS+1];

	assign adv[rtdc_pkg::SQ_STEPS] = out_ready;

	for (genvar j = 0; j < rtdc_pkg::SQ_STEPS; j++) begin : g_step
		logic [rtdc_pkg::RAD_W-1:0]  rad_in;
		logic [rtdc_pkg::REM_W-1:0]  rem_in;
		logic [rtdc_pkg::ROOT_W-1:0] root_in;
		logic                        fahr_in;
		logic                        vld_in;
		logic [rtdc_pkg::REM_W+1:0]  rem_sh;
		logic [rtdc_pkg::REM_W+2:0]  trial;

		if (j == 0) begin : g_first
			assign rad_in  = {1'b0, in_w, {rtdc_pkg::RAD_PAD_W{1'b0}}};
			assign rem_in  = '0;
			assign root_in = '0;
			assign fahr_in = in_fahr;
			assign vld_in  = in_valid;
		end else begin : g_next
			assign rad_in  = rad_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign fahr_in = fahr_s[j-1];
			assign vld_in  = vld_s[j-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_sh = {rem_in, rad_in[rtdc_pkg::RAD_W-1 -: 2]};
		assign trial  = {1'b0, rem_sh} - (rtdc_pkg::REM_W+3)'({root_in, 2'b01});
		assign adv[j] = !vld_s[j] || adv[j+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv[j]) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[j] && vld_in) begin
				rad_s[j]  <= rad_in << 2;
				fahr_s[j] <= fahr_in;
				if (!trial[rtdc_pkg::REM_W+2]) begin
					rem_s[j]  <= trial[rtdc_pkg::REM_W-1:0];
					root_s[j] <= {root_in[rtdc_pkg::ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[j]  <= rem_sh[rtdc_pkg::REM_W-1:0];
					root_s[j] <= {root_in[rtdc_pkg::ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_s[rtdc_pkg::SQ_STEPS-1];
	assign out_root  = root_s[rtdc_pkg::SQ_STEPS-1];
	assign out_fahr  = fahr_s[rtdc_pkg::SQ_STEPS-1];

	// final remainder never exceeds twice the root
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, rem_s[rtdc_pkg::SQ_STEPS-1]} <= {2'b00, out_root, 1'b0}))
		else $error("isqrt remainder out of bound");

	// every root argument is above 2^60, so the root has its top bits set
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_root[rtdc_pkg::ROOT_W-1] || out_root[rtdc_pkg::ROOT_W-2]))
		else $error("isqrt root too small");

	// an accepted transfer always lands in the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s[0])
		else $error("isqrt first stage lost a transfer");

endmodule

// ===== rtl/core/rtd_code_to_temperature.sv =====
`timescale 1ns / 1ps
// throughput: one transfer per cycle while the output is not held, set by the 32-stage
// square root pipeline (one root bit per stage) and the register stages around it
// reset: arst_n clears all stage valid bits and the output valid; data is not reset
// bubbles close up while the output stalls, so input is taken until every stage is full

module rtd_code_to_temperature (
	input  logic                               clk,
	input  logic                               arst_n,
	// input transfer
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [7:0] rtd_high_byte, [15:8] rtd_low_byte
	input  logic [rtdc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [0] use_fahrenheit
	input  logic                               s_axis_tuser,
	// result transfer
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [18:0] temperature_centi (two's complement), [23:19] zero
	output logic [rtdc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	// stage 1: resistance code and root argument
	logic [rtdc_pkg::CODE_W-1:0]        code;
	logic [rtdc_pkg::SLOPE_PROD_W-1:0]  slope_prod;
	logic [rtdc_pkg::W_W-1:0]           w_next;
	logic [rtdc_pkg::W_W-1:0]           w_s1;
	logic                               fahr_s1;
	logic                               vld_s1;
	logic                               adv_s1;

	// square root pipeline
	logic                               sq_in_ready;
	logic                               sq_out_valid;
	logic [rtdc_pkg::ROOT_W-1:0]        sq_root;
	logic                               sq_fahr;

	// stage 2: numerator
	logic signed [rtdc_pkg::NUM_W-1:0]  num_s2;
	logic                               fahr_s2;
	logic                               vld_s2;
	logic                               adv_s2;

	// stage 3: scaled numerator
	logic [rtdc_pkg::MUL_W-1:0]         unit_mul;
	logic signed [rtdc_pkg::PROD_W-1:0] prod_s3;
	logic                               fahr_s3;
	logic                               vld_s3;
	logic                               adv_s3;

	// stage 4: magnitude with half added, shifted down by 2^16
	logic [rtdc_pkg::PROD_W-1:0]        mag;
	logic [rtdc_pkg::PROD_W-1:0]        mag_rnd;
	logic [rtdc_pkg::X_W-1:0]           x_s4;
	logic                               neg_s4;
	logic                               fahr_s4;
	logic                               vld_s4;
	logic                               adv_s4;

	// stage 5: reciprocal estimate of x / 231
	logic [rtdc_pkg::RPROD_W-1:0]       rprod;
	logic [rtdc_pkg::QUOT_W-1:0]        q0_s5;
	logic [rtdc_pkg::X_W-1:0]           x_s5;
	logic                               neg_s5;
	logic                               fahr_s5;
	logic                               vld_s5;
	logic                               adv_s5;

	// stage 6: one correction step of the estimate
	logic [rtdc_pkg::REMD_W-1:0]        q0_times_div;
	logic [rtdc_pkg::REMD_W-1:0]        remd;
	logic [rtdc_pkg::QUOT_W-1:0]        quot;
	logic [rtdc_pkg::QUOT_W-1:0]        quot_s6;
	logic                               neg_s6;
	logic                               fahr_s6;
	logic                               vld_s6;
	logic                               adv_s6;

	// output register: sign and unit offset
	logic [rtdc_pkg::TEMP_W-1:0]        quot_t;
	logic [rtdc_pkg::TEMP_W-1:0]        signed_t;
	logic [rtdc_pkg::TEMP_W-1:0]        temp_next;
	logic [rtdc_pkg::TEMP_W-1:0]        temp_q;
	logic                               out_vld_q;
	logic                               out_adv;

	// a stage moves on when it is empty or the next one moves on
	assign out_adv = !out_vld_q || m_axis_tready;
	assign adv_s6  = !vld_s6 || out_adv;
	assign adv_s5  = !vld_s5 || adv_s6;
	assign adv_s4  = !vld_s4 || adv_s5;
	assign adv_s3  = !vld_s3 || adv_s4;
	assign adv_s2  = !vld_s2 || adv_s3;
	assign adv_s1  = !vld_s1 || sq_in_ready;

	assign s_axis_tready = adv_s1;

	// fault flag in bit 0 of the low byte is dropped
	assign code       = {s_axis_tdata[rtdc_pkg::BYTE_W-1:0],
	                     s_axis_tdata[rtdc_pkg::IN_DATA_W-1:rtdc_pkg::BYTE_W+1]};
	assign slope_prod = rtdc_pkg::SLOPE_PROD_W'(rtdc_pkg::W_SLOPE)
	                    * rtdc_pkg::SLOPE_PROD_W'(code);
	assign w_next     = rtdc_pkg::W_BASE - {1'b0, slope_prod};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			w_s1    <= w_next;
			fahr_s1 <= s_axis_tuser;
		end
	end

	// root of w * 2^16, i.e. the square root term in units of 2^-16
	rtdc_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (sq_in_ready),
		.in_w      (w_s1),
		.in_fahr   (fahr_s1),
		.out_valid (sq_out_valid),
		.out_ready (adv_s2),
		.out_root  (sq_root),
		.out_fahr  (sq_fahr)
	);

	// numerator a - root, may go negative below zero degrees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= sq_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && sq_out_valid) begin
			num_s2  <= $signed({1'b0, rtdc_pkg::A_SCALED}) - $signed({1'b0, sq_root});
			fahr_s2 <= sq_fahr;
		end
	end

	// celsius or fahrenheit scale, centi units folded in
	assign unit_mul = fahr_s2 ? rtdc_pkg::F_MUL : rtdc_pkg::C_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv_s3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) begin
			prod_s3 <= rtdc_pkg::PROD_W'(num_s2)
			           * rtdc_pkg::PROD_W'($signed({1'b0, unit_mul}));
			fahr_s3 <= fahr_s2;
		end
	end

	// round half away from zero: work on the magnitude, sign restored later
	assign mag     = prod_s3[rtdc_pkg::PROD_W-1] ? (-prod_s3) : prod_s3;
	assign mag_rnd = mag + rtdc_pkg::DEN_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && vld_s3) begin
			x_s4    <= mag_rnd[rtdc_pkg::DEN_SHIFT +: rtdc_pkg::X_W];
			neg_s4  <= prod_s3[rtdc_pkg::PROD_W-1];
			fahr_s4 <= fahr_s3;
		end
	end

	// floor(2^34 / 231) keeps the estimate at or one below the true quotient
	assign rprod = rtdc_pkg::RPROD_W'(x_s4) * rtdc_pkg::RPROD_W'(rtdc_pkg::RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv_s5) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && vld_s4) begin
			q0_s5   <= rprod[rtdc_pkg::RPROD_W-1:rtdc_pkg::RECIP_SHIFT];
			x_s5    <= x_s4;
			neg_s5  <= neg_s4;
			fahr_s5 <= fahr_s4;
		end
	end

	// one correction step on the estimate
	assign q0_times_div = rtdc_pkg::REMD_W'(q0_s5) * rtdc_pkg::DIV;
	assign remd         = rtdc_pkg::REMD_W'(x_s5) - q0_times_div;
	assign quot         = (remd >= rtdc_pkg::DIV) ? (q0_s5 + 1'b1) : q0_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv_s6) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s6 && vld_s5) begin
			quot_s6 <= quot;
			neg_s6  <= neg_s5;
			fahr_s6 <= fahr_s5;
		end
	end

	// sign and the 32 degree offset for fahrenheit
	assign quot_t    = rtdc_pkg::TEMP_W'(quot_s6);
	assign signed_t  = neg_s6 ? (-quot_t) : quot_t;
	assign temp_next = fahr_s6 ? (signed_t + rtdc_pkg::F_OFFSET) : signed_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_adv) begin
			out_vld_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && vld_s6) begin
			temp_q <= temp_next;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(rtdc_pkg::OUT_DATA_W - rtdc_pkg::TEMP_W){1'b0}}, temp_q};

	// input back-pressure only once the whole pipe is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled while the pipeline had room");

	// results always within the sensor span
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (($signed(temp_q) >= rtdc_pkg::TEMP_MIN)
		                   && ($signed(temp_q) <= rtdc_pkg::TEMP_MAX)))
		else $error("temperature out of range");

	// the reciprocal estimate is off by at most one
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (remd < (rtdc_pkg::DIV << 1)))
		else $error("divide by 231 estimate off by more than one");

endmodule
